### rtl/core/utf8v_pkg.sv
// shared constants and widths for the utf-8 validator with counts
`default_nettype none

package utf8v_pkg;

  // default buffer length limit in bytes
  localparam int unsigned MaxBytesDefault = 65536;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OffW    = 17;
  localparam int unsigned AdjW    = 17;
  localparam int unsigned AccW    = 21;
  localparam int unsigned SeqLenW = 3;
  localparam int unsigned PendW   = 2;

  // output tdata: offset, utf16 adjust, scalar adjust, padded to whole bytes
  localparam int unsigned OutFieldsW = OffW + AdjW + AdjW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // lead byte classes
  localparam logic [ByteW-1:0] AsciiLimit = 8'h80;
  localparam logic [ByteW-1:0] Lead2Low   = 8'hC2;
  localparam logic [ByteW-1:0] Lead2High  = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Tag   = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Mask  = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Tag   = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Mask  = 8'hF8;
  localparam logic [ByteW-1:0] ContMask   = 8'hC0;
  localparam logic [ByteW-1:0] ContTag    = 8'h80;

  // scalar value limits
  localparam logic [AccW-1:0] Min3Byte   = 21'h000800;
  localparam logic [AccW-1:0] SurrLow    = 21'h00D800;
  localparam logic [AccW-1:0] SurrHigh   = 21'h00DFFF;
  localparam logic [AccW-1:0] Min4Byte   = 21'h010000;
  localparam logic [AccW-1:0] MaxScalar  = 21'h10FFFF;

  // sequence lengths
  localparam logic [SeqLenW-1:0] SeqNone = 3'd0;
  localparam logic [SeqLenW-1:0] Seq2    = 3'd2;
  localparam logic [SeqLenW-1:0] Seq3    = 3'd3;
  localparam logic [SeqLenW-1:0] Seq4    = 3'd4;

endpackage : utf8v_pkg

`default_nettype wire

### rtl/core/utf8_validator_with_counts_core.sv
// utf-8 validator with utf-16 unit and scalar count adjustments
// the result beat is registered in the cycle after the last beat of a buffer
// throughput: one input beat per cycle while s_axis_tready is high; decode and state update sit between
//   the input beat and the per-buffer state and result registers
// an input beat is taken while a result waits, as long as the result slot frees
// reset: clears scan state and the result valid flag; payload regs are not reset
`default_nettype none

module utf8_validator_with_counts_core
  import utf8v_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MaxBytesDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // slave side
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,  // [7:0] data_byte
  input  wire logic [0:0]          s_axis_tuser,  // [0] holds_byte
  input  wire logic                s_axis_tlast,  // last
  // master side
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,  // [16:0] invalid_offset,
                                                  // [33:17] utf16_adjust,
                                                  // [50:34] scalar_adjust, rest 0
  output logic [0:0]               m_axis_tuser   // [0] all_valid
);

  localparam int unsigned PosW = $clog2(MAX_BYTES + 1);
  localparam int unsigned ExtW = (PosW > OffW) ? PosW : OffW;

  // scan state
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    start_q, start_d;
  logic [SeqLenW-1:0] seq_len_q, seq_len_d;
  logic [PendW-1:0]   pend_q, pend_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic               failed_q, failed_d;
  logic [AdjW-1:0]    units_q, units_d;
  logic [AdjW-1:0]    scalars_q, scalars_d;

  // result register
  logic               out_valid_q;
  logic [OffW-1:0]    res_off_q, res_off_d;
  logic               res_ok_q, res_ok_d;
  logic [AdjW-1:0]    res_units_q, res_scalars_q;

  logic               in_fire;
  logic               take_byte;
  logic [ByteW-1:0]   b;
  logic [AccW-1:0]    acc_new;
  logic               bad_end;
  logic [ExtW-1:0]    off_ext;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign take_byte     = in_fire && s_axis_tuser[0] && (pos_q < PosW'(MAX_BYTES));
  assign acc_new       = {acc_q[AccW-7:0], b[5:0]};

  // per-byte decode and state update
  always_comb begin
    pos_d     = pos_q;
    start_d   = start_q;
    seq_len_d = seq_len_q;
    pend_d    = pend_q;
    acc_d     = acc_q;
    failed_d  = failed_q;
    units_d   = units_q;
    scalars_d = scalars_q;
    if (take_byte) begin
      pos_d = pos_q + PosW'(1);
      if (!failed_q) begin
        if (pend_q == '0) begin
          // lead byte
          start_d = pos_q;
          if (b < AsciiLimit) begin
            seq_len_d = SeqNone;
            pend_d    = '0;
          end else if (b >= Lead2Low && b <= Lead2High) begin
            seq_len_d = Seq2;
            pend_d    = PendW'(1);
            acc_d     = AccW'(b[4:0]);
          end else if ((b & Lead3Mask) == Lead3Tag) begin
            seq_len_d = Seq3;
            pend_d    = PendW'(2);
            acc_d     = AccW'(b[3:0]);
          end else if ((b & Lead4Mask) == Lead4Tag) begin
            seq_len_d = Seq4;
            pend_d    = PendW'(3);
            acc_d     = AccW'(b[2:0]);
          end else begin
            failed_d  = 1'b1;
            pend_d    = '0;
            seq_len_d = SeqNone;
          end
        end else if ((b & ContMask) != ContTag) begin
          // missing continuation
          failed_d  = 1'b1;
          pend_d    = '0;
          seq_len_d = SeqNone;
        end else begin
          acc_d  = acc_new;
          pend_d = pend_q - PendW'(1);
          if (pend_q == PendW'(1)) begin
            // sequence complete: range checks and count adjustment
            seq_len_d = SeqNone;
            case (seq_len_q)
              Seq2: begin
                units_d   = units_q - AdjW'(1);
                scalars_d = scalars_q - AdjW'(1);
              end
              Seq3: begin
                if (acc_new < Min3Byte || (acc_new >= SurrLow && acc_new <= SurrHigh)) begin
                  failed_d = 1'b1;
                end else begin
                  units_d   = units_q - AdjW'(2);
                  scalars_d = scalars_q - AdjW'(2);
                end
              end
              default: begin
                if (acc_new < Min4Byte || acc_new > MaxScalar) begin
                  failed_d = 1'b1;
                end else begin
                  units_d   = units_q - AdjW'(2);
                  scalars_d = scalars_q - AdjW'(3);
                end
              end
            endcase
          end
        end
      end
    end
  end

  // end of buffer: a sequence still open counts as truncated
  assign bad_end  = failed_d || (pend_d != '0);
  assign off_ext  = bad_end ? ExtW'(start_d) : ExtW'(pos_d);
  assign res_off_d = off_ext[OffW-1:0];
  assign res_ok_d  = !bad_end;

  // scan state registers, cleared after each buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      start_q   <= '0;
      seq_len_q <= SeqNone;
      pend_q    <= '0;
      acc_q     <= '0;
      failed_q  <= 1'b0;
      units_q   <= '0;
      scalars_q <= '0;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        pos_q     <= '0;
        start_q   <= '0;
        seq_len_q <= SeqNone;
        pend_q    <= '0;
        acc_q     <= '0;
        failed_q  <= 1'b0;
        units_q   <= '0;
        scalars_q <= '0;
      end else begin
        pos_q     <= pos_d;
        start_q   <= start_d;
        seq_len_q <= seq_len_d;
        pend_q    <= pend_d;
        acc_q     <= acc_d;
        failed_q  <= failed_d;
        units_q   <= units_d;
        scalars_q <= scalars_d;
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && s_axis_tlast) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tlast) begin
      res_off_q     <= res_off_d;
      res_ok_q      <= res_ok_d;
      res_units_q   <= units_d;
      res_scalars_q <= scalars_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({res_scalars_q, res_units_q, res_off_q});
  assign m_axis_tuser  = res_ok_q;

  // an open sequence has more bytes than it still waits for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != '0) |-> (seq_len_q > SeqLenW'(pend_q)))
    else $error("pending count does not match sequence length");

  // a failed scan keeps no open sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> (pend_q == '0 && seq_len_q == SeqNone))
    else $error("open sequence after failure");

  // a last beat yields a result and a cleared scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> (out_valid_q && pos_q == '0 && !failed_q))
    else $error("last beat did not produce a result or clear the scan");

  // scalar adjustment never exceeds the utf-16 adjustment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $signed(scalars_q) <= $signed(units_q))
    else $error("scalar adjust above utf-16 adjust");

endmodule : utf8_validator_with_counts_core

`default_nettype wire
